### rtl/rfrb_pkg.sv
package rfrb_pkg;

  localparam int OUT_CAP = 32;

  localparam int FLAG_MARKER = 0;
  localparam int FLAG_FRAG   = 1;
  localparam int FLAG_START  = 2;
  localparam int FLAG_END    = 3;

  typedef struct packed {
    logic [31:0] ts;
    logic [3:0]  flags;
    logic [15:0] len;
    logic [15:0] handle;
  } slot_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD1,
    ST_MOD2,
    ST_REF,
    ST_REF_W,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_CMP_RD,
    ST_CMP_ACC,
    ST_EM_RD,
    ST_EM_OUT,
    ST_OVF
  } state_t;

endpackage

### rtl/rfrb_slot_mem.sv
module rfrb_slot_mem #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(SLOT_COUNT)-1:0] waddr,
  input  rfrb_pkg::slot_entry_t         wdata,
  input  logic                          re,
  input  logic [$clog2(SLOT_COUNT)-1:0] raddr,
  output rfrb_pkg::slot_entry_t         rdata
);
  import rfrb_pkg::*;

  slot_entry_t mem [SLOT_COUNT];
  slot_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/rtp_frame_reassembly_buffer_unit.sv
// Each packet is placed in its slot; then, unless it is held out of order, the head slot is
// read, slots are scanned and checked for fragment balance, and descriptors are emitted.
// A new packet is taken only in the idle state, once the previous one is fully processed;
// the one slot memory read port serializes all slot reads, and output stalls hold emission.
// Reset: synchronous, active low; clears all slot valid bits, closes the frame and
// zeroes head and missing sequence numbers. Slot contents are not cleared.
module rtp_frame_reassembly_buffer_unit #(
  parameter int SLOT_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // seq_number, rtp_timestamp, payload_length, payload_handle
  input  logic [2:0]  in_tuser,  // is_fragment, frag_start, frag_end
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // frame_timestamp, out_handle, out_length
  output logic [3:0]  out_tuser, // status, out_fragment, out_frag_start, out_frag_end
  output logic        out_tlast
);
  import rfrb_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int GW = $clog2(SLOT_COUNT + 1);
  localparam longint RECIP = (64'd1 << 24) / SLOT_COUNT;
  localparam int RW = $clog2(RECIP + 1);

  state_t state_r, state_nxt;

  logic [15:0] seq_r, seq_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] hdl_r, hdl_nxt;
  logic [15:0] q_r, q_nxt;

  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [31:0] open_ts_r, open_ts_nxt;
  logic        open_r, open_nxt;
  logic [15:0] head_r, head_nxt;
  logic [SW-1:0] head_slot_r, head_slot_nxt;
  logic [15:0] miss_r, miss_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic [SW-1:0] cur_slot_r, cur_slot_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [SW-1:0] pos_slot_r, pos_slot_nxt;
  logic [31:0] ref_r, ref_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [SW-1:0] ix_slot_r, ix_slot_nxt;
  logic [16:0] diff_r, diff_nxt;
  logic [5:0]  n_r, n_nxt;
  logic [GW-1:0] guard_r, guard_nxt;
  logic [SW-1:0] scan_i_r, scan_i_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [3:0]  out_user_r, out_user_nxt;
  logic        out_last_r, out_last_nxt;

  logic        mem_we, mem_re;
  logic [SW-1:0] mem_waddr, mem_raddr;
  slot_entry_t mem_wdata, rd;

  logic [15+RW:0] prod;
  logic [16:0]    rem_raw;
  logic [SW-1:0]  k;
  logic           out_free;
  logic [16:0]    diff_upd;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
    return (s == '0) ? SW'(SLOT_COUNT - 1) : s - 1'b1;
  endfunction

  rfrb_slot_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  assign prod     = seq_r * RW'(RECIP);
  assign rem_raw  = {1'b0, seq_r} - 17'(q_r * 17'(SLOT_COUNT));
  assign k        = (rem_raw >= 17'(SLOT_COUNT)) ? SW'(rem_raw - 17'(SLOT_COUNT)) : SW'(rem_raw);
  assign out_free = !out_valid_r || out_tready;
  assign diff_upd = rd.flags[FLAG_FRAG]
                  ? diff_r + 17'(rd.flags[FLAG_START]) - 17'(rd.flags[FLAG_END])
                  : diff_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      open_ts_r   <= '0;
      open_r      <= 1'b0;
      head_r      <= '0;
      head_slot_r <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      guard_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      open_ts_r   <= open_ts_nxt;
      open_r      <= open_nxt;
      head_r      <= head_nxt;
      head_slot_r <= head_slot_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      guard_r     <= guard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r      <= seq_nxt;
    ts_r       <= ts_nxt;
    flags_r    <= flags_nxt;
    len_r      <= len_nxt;
    hdl_r      <= hdl_nxt;
    q_r        <= q_nxt;
    cur_r      <= cur_nxt;
    cur_slot_r <= cur_slot_nxt;
    pos_r      <= pos_nxt;
    pos_slot_r <= pos_slot_nxt;
    ref_r      <= ref_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    ix_slot_r  <= ix_slot_nxt;
    diff_r     <= diff_nxt;
    scan_i_r   <= scan_i_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    ts_nxt        = ts_r;
    flags_nxt     = flags_r;
    len_nxt       = len_r;
    hdl_nxt       = hdl_r;
    q_nxt         = q_r;
    valid_nxt     = valid_r;
    open_ts_nxt   = open_ts_r;
    open_nxt      = open_r;
    head_nxt      = head_r;
    head_slot_nxt = head_slot_r;
    miss_nxt      = miss_r;
    cur_nxt       = cur_r;
    cur_slot_nxt  = cur_slot_r;
    pos_nxt       = pos_r;
    pos_slot_nxt  = pos_slot_r;
    ref_nxt       = ref_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    ix_slot_nxt   = ix_slot_r;
    diff_nxt      = diff_r;
    n_nxt         = n_r;
    guard_nxt     = guard_r;
    scan_i_nxt    = scan_i_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = k;
    mem_wdata     = '{ts: ts_r, flags: flags_r, len: len_r, handle: hdl_r};
    mem_re        = 1'b0;
    mem_raddr     = cur_slot_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          seq_nxt   = in_tdata[15:0];
          ts_nxt    = in_tdata[47:16];
          len_nxt   = in_tdata[63:48];
          hdl_nxt   = in_tdata[79:64];
          flags_nxt = {in_tuser[2], in_tuser[1], in_tuser[0], in_tlast};
          state_nxt = ST_MOD1;
        end
      end
      ST_MOD1: begin
        q_nxt     = 16'(prod[15+RW:24]);
        state_nxt = ST_MOD2;
      end
      ST_MOD2: begin
        mem_we     = 1'b1;
        n_nxt      = '0;
        guard_nxt  = '0;
        state_nxt  = ST_REF;
        if (!open_r || open_ts_r != ts_r) begin
          valid_nxt     = '0;
          open_ts_nxt   = ts_r;
          open_nxt      = 1'b1;
          head_nxt      = seq_r;
          head_slot_nxt = k;
          miss_nxt      = seq_r + 16'd1;
          cur_nxt       = seq_r;
          cur_slot_nxt  = k;
        end else if (((seq_r - head_r) & 16'h8000) != 16'd0) begin
          head_nxt      = seq_r;
          head_slot_nxt = k;
          cur_nxt       = seq_r;
          cur_slot_nxt  = k;
        end else if (seq_r == miss_r) begin
          cur_nxt       = seq_r;
          cur_slot_nxt  = k;
        end else begin
          state_nxt     = ST_IDLE;
        end
        valid_nxt[k] = 1'b1;
      end
      ST_REF: begin
        mem_re    = 1'b1;
        mem_raddr = head_slot_r;
        state_nxt = ST_REF_W;
      end
      ST_REF_W: begin
        ref_nxt    = rd.ts;
        scan_i_nxt = '0;
        state_nxt  = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (!valid_r[cur_slot_r]) begin
          miss_nxt      = cur_r;
          state_nxt     = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        idx_nxt     = '0;
        ix_slot_nxt = head_slot_r;
        diff_nxt    = '0;
        if (rd.ts != ref_r) begin
          pos_nxt      = cur_r - 16'd1;
          pos_slot_nxt = slot_dec(cur_slot_r);
          cnt_nxt      = cur_r - head_r;
          state_nxt    = (cur_r == head_r) ? ST_IDLE : ST_CMP_RD;
        end else if (rd.flags[FLAG_MARKER]) begin
          pos_nxt      = cur_r;
          pos_slot_nxt = cur_slot_r;
          cnt_nxt      = cur_r - head_r + 16'd1;
          state_nxt    = (cur_r - head_r + 16'd1 == 16'd0) ? ST_IDLE : ST_CMP_RD;
        end else if (scan_i_r == SW'(SLOT_COUNT - 1)) begin
          state_nxt = ST_OVF;
        end else begin
          scan_i_nxt   = scan_i_r + 1'b1;
          cur_nxt      = cur_r + 16'd1;
          cur_slot_nxt = slot_inc(cur_slot_r);
          state_nxt    = ST_SCAN_RD;
        end
      end
      ST_CMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ix_slot_r;
        state_nxt = ST_CMP_ACC;
      end
      ST_CMP_ACC: begin
        diff_nxt    = diff_upd;
        idx_nxt     = idx_r + 16'd1;
        ix_slot_nxt = slot_inc(ix_slot_r);
        state_nxt   = ST_CMP_RD;
        if (idx_r + 16'd1 == cnt_r) begin
          idx_nxt     = '0;
          ix_slot_nxt = head_slot_r;
          state_nxt   = (diff_upd != '0) ? ST_IDLE : ST_EM_RD;
        end
      end
      ST_EM_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ix_slot_r;
        state_nxt = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        if (!(n_r < 6'(OUT_CAP) && !out_free)) begin
          valid_nxt[ix_slot_r] = 1'b0;
          if (n_r < 6'(OUT_CAP)) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {rd.len, rd.handle, ref_r};
            out_user_nxt  = {rd.flags[FLAG_FRAG] & rd.flags[FLAG_END],
                             rd.flags[FLAG_FRAG] & rd.flags[FLAG_START],
                             rd.flags[FLAG_FRAG], 1'b0};
            out_last_nxt  = (idx_r + 16'd1 == cnt_r);
            n_nxt         = n_r + 6'd1;
          end
          idx_nxt     = idx_r + 16'd1;
          ix_slot_nxt = slot_inc(ix_slot_r);
          state_nxt   = ST_EM_RD;
          if (idx_r + 16'd1 == cnt_r) begin
            open_nxt      = 1'b0;
            head_nxt      = pos_r + 16'd1;
            head_slot_nxt = slot_inc(pos_slot_r);
            cur_nxt       = pos_r + 16'd1;
            cur_slot_nxt  = slot_inc(pos_slot_r);
            guard_nxt     = guard_r + 1'b1;
            state_nxt     = (guard_r == GW'(SLOT_COUNT)) ? ST_IDLE : ST_REF;
          end
        end
      end
      ST_OVF: begin
        if (n_r >= 6'(OUT_CAP)) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {32'd0, open_ts_r};
          out_user_nxt  = 4'b0001;
          out_last_nxt  = 1'b0;
          n_nxt         = n_r + 6'd1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sim/rtp_frame_reassembly_buffer_unit_tb.sv
`timescale 1ns / 100ps

module rtp_frame_reassembly_buffer_unit_tb;
  import rfrb_pkg::*;

  localparam int SLOTS = 32;

  typedef struct {
    bit [15:0] seq;
    bit [31:0] ts;
    bit        marker;
    bit        frag;
    bit        fstart;
    bit        fend;
    bit [15:0] len;
    bit [15:0] handle;
  } packet_t;

  typedef struct {
    bit        status;
    bit [31:0] ts;
    bit [15:0] handle;
    bit [15:0] len;
    bit        frag;
    bit        fstart;
    bit        fend;
    bit        last;
  } descriptor_t;

  class frame_scoreboard;
    bit          valid_q[SLOTS];
    bit [31:0]   ts_q[SLOTS];
    bit [3:0]    flags_q[SLOTS];
    bit [15:0]   len_q[SLOTS];
    bit [15:0]   handle_q[SLOTS];
    bit [31:0]   open_ts;
    bit          open_q;
    bit [15:0]   head;
    bit [15:0]   missing;
    descriptor_t expected_q[$];
    int          errors;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // 0 gap found, 1 frame ends at pos, 2 overflow
    function int scan_frame(bit [15:0] from, output bit [15:0] pos);
      bit [31:0] ref_ts;
      bit [15:0] s;
      ref_ts = ts_q[head[4:0]];
      for (int i = 0; i < SLOTS; i++) begin
        s = from + 16'(i);
        if (!valid_q[s[4:0]]) begin
          pos = s;
          return 0;
        end
        if (ts_q[s[4:0]] != ref_ts) begin
          pos = s - 16'd1;
          return 1;
        end
        if (flags_q[s[4:0]][FLAG_MARKER]) begin
          pos = s;
          return 1;
        end
      end
      return 2;
    endfunction

    function bit balanced(bit [15:0] a, bit [15:0] b);
      bit [15:0] cnt, s;
      int ns, ne;
      cnt = b - a + 16'd1;
      ns = 0;
      ne = 0;
      for (int i = 0; i < int'(cnt); i++) begin
        s = a + 16'(i);
        if (flags_q[s[4:0]][FLAG_FRAG]) begin
          ns += flags_q[s[4:0]][FLAG_START];
          ne += flags_q[s[4:0]][FLAG_END];
        end
      end
      return ns == ne;
    endfunction

    function void note(packet_t p);
      bit [15:0]   from, pos, cnt, s;
      bit [3:0]    f;
      bit [31:0]   fts;
      bit          noscan;
      int          r, n;
      descriptor_t d;
      noscan = 0;
      n = 0;
      from = p.seq;
      if (!open_q || open_ts != p.ts) begin
        foreach (valid_q[i]) valid_q[i] = 0;
        open_ts = p.ts;
        open_q = 1;
        head = p.seq;
        missing = p.seq + 16'd1;
      end else if ((p.seq - head) & 16'h8000) begin
        head = p.seq;
      end else if (p.seq != missing) begin
        noscan = 1;
      end
      valid_q[p.seq[4:0]] = 1;
      ts_q[p.seq[4:0]] = p.ts;
      flags_q[p.seq[4:0]] = {p.fend, p.fstart, p.frag, p.marker};
      len_q[p.seq[4:0]] = p.len;
      handle_q[p.seq[4:0]] = p.handle;
      if (noscan) return;
      for (int g = 0; g <= SLOTS; g++) begin
        r = scan_frame(from, pos);
        if (r == 2) begin
          d = '{1'b1, open_ts, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0};
          if (n < OUT_CAP) expected_q.push_back(d);
          return;
        end
        if (r == 0) begin
          missing = pos;
          return;
        end
        if (!balanced(head, pos)) return;
        cnt = pos - head + 16'd1;
        if (cnt == 0) return;
        fts = ts_q[head[4:0]];
        for (int i = 0; i < int'(cnt); i++) begin
          s = head + 16'(i);
          f = flags_q[s[4:0]];
          valid_q[s[4:0]] = 0;
          d = '{1'b0, fts, handle_q[s[4:0]], len_q[s[4:0]], f[FLAG_FRAG],
                f[FLAG_FRAG] & f[FLAG_START], f[FLAG_FRAG] & f[FLAG_END],
                i + 1 == int'(cnt)};
          if (n < OUT_CAP) begin
            expected_q.push_back(d);
            n++;
          end
        end
        open_q = 0;
        head = pos + 16'd1;
        from = head;
      end
    endfunction

    task check(descriptor_t got);
      descriptor_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected descriptor handle %h", got.handle));
        return;
      end
      e = expected_q.pop_front();
      if (got.status != e.status) report($sformatf("status %0d exp %0d", got.status, e.status));
      if (got.ts != e.ts) report($sformatf("timestamp %h exp %h", got.ts, e.ts));
      if (got.handle != e.handle) report($sformatf("handle %h exp %h", got.handle, e.handle));
      if (got.len != e.len) report($sformatf("length %h exp %h", got.len, e.len));
      if (got.frag != e.frag) report($sformatf("fragment %0d exp %0d", got.frag, e.frag));
      if (got.fstart != e.fstart) report($sformatf("start %0d exp %0d", got.fstart, e.fstart));
      if (got.fend != e.fend) report($sformatf("end %0d exp %0d", got.fend, e.fend));
      if (got.last != e.last) report($sformatf("last %0d exp %0d", got.last, e.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  frame_scoreboard sb = new();
  int          sent;
  int          burst_left;
  bit [15:0]   next_seq;
  packet_t     frame_q[$];

  rtp_frame_reassembly_buffer_unit #(.SLOT_COUNT(SLOTS)) dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    packet_t p;
    descriptor_t d;
    if (rst_n && in_tvalid && in_tready) begin
      p = '{in_tdata[15:0], in_tdata[47:16], in_tlast, in_tuser[0], in_tuser[1],
            in_tuser[2], in_tdata[63:48], in_tdata[79:64]};
      sb.note(p);
    end
    if (rst_n && out_tvalid && out_tready) begin
      d = '{out_tuser[0], out_tdata[31:0], out_tdata[47:32], out_tdata[63:48],
            out_tuser[1], out_tuser[2], out_tuser[3], out_tlast};
      sb.check(d);
    end
  end

  // receiver: random stalls, free-running stretches, one long hold-off
  initial begin
    bit held;
    int mode_left;
    bit free_run;
    held = 0;
    mode_left = 0;
    free_run = 0;
    out_tready <= 0;
    @(posedge clk);
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held && sent >= 120) begin
        held = 1;
        out_tready <= 0;
        repeat (400) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(60, 5);
        free_run = $urandom_range(2) == 0;
      end
      mode_left--;
      out_tready <= free_run ? 1'b1 : ($urandom_range(3) != 0);
    end
  end

  task send(packet_t p);
    in_tvalid <= 1;
    in_tdata <= {p.handle, p.len, p.ts, p.seq};
    in_tuser <= {p.fend, p.fstart, p.frag};
    in_tlast <= p.marker;
    do @(posedge clk); while (!in_tready);
    sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      if ($urandom_range(3) != 0) begin
        in_tvalid <= 0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task send_fields(bit [15:0] seq, bit [31:0] ts, bit m, bit fr, bit fs, bit fe,
                   bit [15:0] len, bit [15:0] h);
    packet_t p;
    p = '{seq, ts, m, fr, fs, fe, len, h};
    send(p);
  endtask

  // build one frame of well-formed packets with random content, then disturb it
  task random_frame();
    packet_t p;
    bit [31:0] ts;
    int n, i;
    ts = $urandom();
    n = ($urandom_range(19) == 0) ? 34 : $urandom_range(8, 1);
    frame_q.delete();
    for (i = 0; i < n; i++) begin
      p.seq = next_seq + 16'(i);
      p.ts = ts;
      p.marker = (i == n - 1) && (n != 34);
      p.frag = 1'($urandom_range(1));
      p.fstart = (i == 0) ? 1'b1 : 1'($urandom_range(1));
      p.fend = (i == n - 1) ? 1'b1 : 1'($urandom_range(1));
      if ($urandom_range(7) != 0 && n > 1) begin
        p.frag = 1;
        p.fstart = (i == 0);
        p.fend = (i == n - 1);
      end
      p.len = 16'($urandom());
      p.handle = 16'($urandom());
      frame_q.push_back(p);
    end
    next_seq += 16'(n);
    if (n > 1 && $urandom_range(3) == 0) begin
      i = $urandom_range(n - 2);
      p = frame_q[i];
      frame_q[i] = frame_q[i + 1];
      frame_q[i + 1] = p;
    end
    if (n > 2 && $urandom_range(9) == 0) frame_q.delete($urandom_range(n - 1, 1));
    foreach (frame_q[j]) send(frame_q[j]);
  endtask

  initial begin
    packet_t p;
    sent = 0;
    burst_left = 0;
    rst_n <= 0;
    in_tvalid <= 0;
    in_tdata <= '0;
    in_tuser <= '0;
    in_tlast <= 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // fill every slot of one frame: overflow on the last
    for (int i = 0; i < SLOTS; i++)
      send_fields(16'(i), 32'h0000_00a5, 1'b0, i[0], i[1], i[2], 16'(i * 3), 16'(i));
    send_fields(16'd100, 32'h1111_0000, 1'b1, 1'b0, 1'b1, 1'b1, 16'hffff, 16'h0000);
    send_fields(16'd101, 32'h2222_0000, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0, 16'hffff);
    send_fields(16'd102, 32'h2222_0000, 1'b0, 1'b1, 1'b0, 1'b0, 16'd10, 16'h1234);
    send_fields(16'd103, 32'h2222_0000, 1'b1, 1'b1, 1'b0, 1'b1, 16'd20, 16'h5678);
    // unbalanced fragments hold, then the end packet completes it
    send_fields(16'd104, 32'h3333_0000, 1'b1, 1'b1, 1'b1, 1'b0, 16'd5, 16'h0104);
    send_fields(16'd105, 32'h3333_0000, 1'b1, 1'b1, 1'b0, 1'b1, 16'd6, 16'h0105);
    // out of order: later packet held, earlier packet moves the head
    send_fields(16'd300, 32'h4444_0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1, 16'h0300);
    send_fields(16'd302, 32'h4444_0000, 1'b1, 1'b0, 1'b0, 1'b0, 16'd3, 16'h0302);
    send_fields(16'd299, 32'h4444_0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'h0299);
    send_fields(16'd301, 32'h4444_0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'd2, 16'h0301);
    // sequence wrap, extreme values
    send_fields(16'hffff, 32'hffff_ffff, 1'b0, 1'b1, 1'b1, 1'b0, 16'hffff, 16'hffff);
    send_fields(16'h0000, 32'hffff_ffff, 1'b1, 1'b1, 1'b1, 1'b1, 16'hffff, 16'hffff);
    send_fields(16'h0001, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);

    next_seq = 16'd2;
    while (sent < 250) begin
      if ($urandom_range(9) == 0) begin
        p = '{16'($urandom()), $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom()),
              16'($urandom())};
        send(p);
      end else begin
        random_frame();
      end
    end
    in_tvalid <= 0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/rfrb_pkg.sv
rtl/rfrb_slot_mem.sv
rtl/rtp_frame_reassembly_buffer_unit.sv
sim/rtp_frame_reassembly_buffer_unit_tb.sv
